/* sv/lbc_pkg.sv */
package lbc_pkg;

  localparam int LUX_W     = 17;
  localparam int BRI_W     = 8;
  localparam int PT_W      = LUX_W + BRI_W;
  localparam int LIM_W     = 24;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = 3;
  localparam int NUM_W     = LUX_W + BRI_W;
  localparam int DIV_STEPS = BRI_W;

  // register map
  localparam logic [IDX_W-1:0] REG_COUNT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_POINT0 = 3'd1;
  localparam logic [IDX_W-1:0] REG_LIMITS = 3'd7;

  // min 0, max 255, fallback 0
  localparam logic [LIM_W-1:0] LIMITS_RESET = 24'h00FF00;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // segment select result
  typedef struct packed {
    logic             err;
    logic             direct;
    logic [BRI_W-1:0] dval;
    logic [LUX_W-1:0] x;
    logic [LUX_W-1:0] x1;
    logic [LUX_W-1:0] x2;
    logic [BRI_W-1:0] y1;
    logic [BRI_W-1:0] y2;
  } sel_t;

  // one divider stage
  typedef struct packed {
    logic             err;
    logic             neg;
    logic [BRI_W-1:0] y1;
    logic [NUM_W-1:0] rem;
    logic [LUX_W-1:0] den;
    logic [BRI_W-1:0] quo;
  } div_t;

  function automatic logic [LUX_W-1:0] pt_lux(input logic [PT_W-1:0] pt);
    return pt[LUX_W-1:0];
  endfunction

  function automatic logic [BRI_W-1:0] pt_bri(input logic [PT_W-1:0] pt);
    return pt[PT_W-1:LUX_W];
  endfunction

endpackage

/* sv/lux_to_brightness_curve.sv */
// Lux to brightness curve. Maps one ambient-light reading (lux, lux_valid) to a
// display brightness through up to MAX_POINTS breakpoints written over the cfg
// port. Between two points the result is y1 + floor((y2-y1)(x-x1)/(x2-x1)),
// exact; at or beyond an end point it is that point's brightness. With no
// points the fallback brightness is used, with one point its brightness. The
// value is clamped to min, then to max (max wins). A NaN reading
// (lux_valid = 0) gives status 1 and brightness 0. Throughput is one beat per
// clock while result_stall does not hold the output register back.
// The accepting edge loads the select stage, then come the multiply stage,
// eight restoring-divider stages (one quotient bit each) and the output
// register. Configuration must be written only while the pipeline is empty.
module lux_to_brightness_curve #(
  parameter int MAX_POINTS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lbc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lbc_pkg::PT_W-1:0]   cfg_data,
  // sample channel
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic [lbc_pkg::LUX_W-1:0]  lux,
  input  logic                       lux_valid,
  // result channel
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [lbc_pkg::BRI_W-1:0]  brightness,
  output logic                       status
);

  localparam int LUX_W     = lbc_pkg::LUX_W;
  localparam int BRI_W     = lbc_pkg::BRI_W;
  localparam int PT_W      = lbc_pkg::PT_W;
  localparam int CNT_W     = lbc_pkg::CNT_W;
  localparam int IDX_W     = lbc_pkg::IDX_W;
  localparam int NUM_W     = lbc_pkg::NUM_W;
  localparam int DIV_STEPS = lbc_pkg::DIV_STEPS;

  // ---------------------------------------------------------------------------
  // Configuration registers. Points beyond MAX_POINTS are never read, so they
  // are not stored.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]          point_count;
  logic [PT_W-1:0]           pts [MAX_POINTS];
  logic [lbc_pkg::LIM_W-1:0] limits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      limits      <= lbc_pkg::LIMITS_RESET;
      for (int i = 0; i < MAX_POINTS; i++) begin
        pts[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == lbc_pkg::REG_COUNT) begin
        point_count <= cfg_data[CNT_W-1:0];
      end
      if (cfg_index == lbc_pkg::REG_LIMITS) begin
        limits <= cfg_data[lbc_pkg::LIM_W-1:0];
      end
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (cfg_index == IDX_W'(lbc_pkg::REG_POINT0 + i)) begin
          pts[i] <= cfg_data;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: a stage moves when it is empty or the next one moves, so
  // bubbles are squeezed out and the input stays open while a result waits, as long as some stage is empty.
  // ---------------------------------------------------------------------------
  logic                 sel_v;
  logic                 sel_en;
  logic [DIV_STEPS:0]   dv_v;
  logic [DIV_STEPS:0]   dv_en;
  logic                 out_en;

  always_comb begin
    out_en           = !result_valid || !result_stall;
    dv_en[DIV_STEPS] = !dv_v[DIV_STEPS] || out_en;
    for (int k = DIV_STEPS - 1; k >= 0; k--) begin
      dv_en[k] = !dv_v[k] || dv_en[k+1];
    end
    sel_en = !sel_v || dv_en[0];
  end

  assign sample_stall = !sel_en;

  // ---------------------------------------------------------------------------
  // Stage 1: pick the segment. End checks first, then first exact match or
  // first bracketing pair in point order.
  // ---------------------------------------------------------------------------
  lbc_pkg::sel_t    sel;
  lbc_pkg::sel_t    sel_next;
  logic [CNT_W-1:0] cnt_eff;
  logic [LUX_W-1:0] last_x;
  logic [BRI_W-1:0] last_y;
  logic             scan_found;

  always_comb begin
    cnt_eff = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;
    last_x  = '0;
    last_y  = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (CNT_W'(i + 1) == cnt_eff) begin
        last_x = lbc_pkg::pt_lux(pts[i]);
        last_y = lbc_pkg::pt_bri(pts[i]);
      end
    end
  end

  always_comb begin
    sel_next        = '0;
    sel_next.err    = !lux_valid;
    sel_next.x      = lux;
    sel_next.direct = 1'b1;
    scan_found      = 1'b0;
    if (cnt_eff == '0) begin
      sel_next.dval = limits[23:16];
    end else if (cnt_eff == CNT_W'(1)) begin
      sel_next.dval = lbc_pkg::pt_bri(pts[0]);
    end else if (lux <= lbc_pkg::pt_lux(pts[0])) begin
      sel_next.dval = lbc_pkg::pt_bri(pts[0]);
    end else if (lux >= last_x) begin
      sel_next.dval = last_y;
    end else begin
      // unsorted curve with no bracketing pair falls back to the last point
      sel_next.dval = last_y;
      for (int i = 0; i < MAX_POINTS - 1; i++) begin
        if (!scan_found && (CNT_W'(i + 1) < cnt_eff)) begin
          if (lux == lbc_pkg::pt_lux(pts[i])) begin
            scan_found    = 1'b1;
            sel_next.dval = lbc_pkg::pt_bri(pts[i]);
          end else if ((lbc_pkg::pt_lux(pts[i]) < lux) &&
                       (lux < lbc_pkg::pt_lux(pts[i+1]))) begin
            scan_found    = 1'b1;
            sel_next.dval = lbc_pkg::pt_bri(pts[i]);
            if (lbc_pkg::pt_bri(pts[i]) != lbc_pkg::pt_bri(pts[i+1])) begin
              sel_next.direct = 1'b0;
              sel_next.x1     = lbc_pkg::pt_lux(pts[i]);
              sel_next.x2     = lbc_pkg::pt_lux(pts[i+1]);
              sel_next.y1     = lbc_pkg::pt_bri(pts[i]);
              sel_next.y2     = lbc_pkg::pt_bri(pts[i+1]);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_v <= 1'b0;
    end else if (sel_en) begin
      sel_v <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_en) begin
      sel <= sel_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: deltas and |dy| * dx. A direct value rides through as y1 with a
  // zero numerator so the divider yields zero.
  // ---------------------------------------------------------------------------
  lbc_pkg::div_t    dv      [DIV_STEPS+1];
  lbc_pkg::div_t    dv_next [DIV_STEPS+1];
  logic [LUX_W-1:0] dx;
  logic [BRI_W-1:0] dy_mag;

  always_comb begin
    dx = sel.x - sel.x1;
    dv_next[0]     = '0;
    dv_next[0].err = sel.err;
    if (sel.direct) begin
      dy_mag         = '0;
      dv_next[0].y1  = sel.dval;
      dv_next[0].den = LUX_W'(1);
    end else begin
      if (sel.y2 >= sel.y1) begin
        dy_mag = sel.y2 - sel.y1;
      end else begin
        dy_mag         = sel.y1 - sel.y2;
        dv_next[0].neg = 1'b1;
      end
      dv_next[0].y1  = sel.y1;
      dv_next[0].den = sel.x2 - sel.x1;
      dv_next[0].rem = {{LUX_W{1'b0}}, dy_mag} * {{BRI_W{1'b0}}, dx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (dv_en[0]) begin
      dv_v[0] <= sel_v;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_en[0]) begin
      dv[0] <= dv_next[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage, MSB first. The quotient is
  // bounded by |dy| < 256, so BRI_W steps suffice.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int B = DIV_STEPS - 1 - k;
    logic [NUM_W-1:0] trial;

    always_comb begin
      trial          = NUM_W'(dv[k].den) << B;
      dv_next[k+1]   = dv[k];
      if (dv[k].rem >= trial) begin
        dv_next[k+1].rem    = dv[k].rem - trial;
        dv_next[k+1].quo[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (dv_en[k+1]) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (dv_en[k+1]) begin
        dv[k+1] <= dv_next[k+1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output: floor for a falling segment, add to y1, clamp min then max.
  // ---------------------------------------------------------------------------
  logic [BRI_W:0]   q_mag;
  logic [BRI_W:0]   sum;
  logic [BRI_W-1:0] clamped;
  logic [BRI_W-1:0] lim_lo;
  logic [BRI_W-1:0] lim_hi;

  always_comb begin
    lim_lo = limits[7:0];
    lim_hi = limits[15:8];
    q_mag  = {1'b0, dv[DIV_STEPS].quo};
    if (dv[DIV_STEPS].neg) begin
      if (dv[DIV_STEPS].rem != '0) begin
        q_mag = q_mag + (BRI_W+1)'(1);
      end
      sum = {1'b0, dv[DIV_STEPS].y1} - q_mag;
    end else begin
      sum = {1'b0, dv[DIV_STEPS].y1} + q_mag;
    end
    clamped = sum[BRI_W-1:0];
    if (clamped < lim_lo) begin
      clamped = lim_lo;
    end
    if (clamped > lim_hi) begin
      clamped = lim_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_en) begin
      result_valid <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      if (dv[DIV_STEPS].err) begin
        brightness <= '0;
        status     <= lbc_pkg::STATUS_ERR;
      end else begin
        brightness <= clamped;
        status     <= lbc_pkg::STATUS_OK;
      end
    end
  end

endmodule

/* sv/lbc_checker.sv */
module lbc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      sample_stall,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic [lbc_pkg::BRI_W-1:0] brightness,
  input logic                      status
);

  // input only backs up when the result side is holding a beat
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall))
    else $error("sample stall without a held result");

  // error beats carry zero brightness
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status == lbc_pkg::STATUS_ERR)) |-> (brightness == '0))
    else $error("error beat with nonzero brightness");

  // held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(brightness) && $stable(status)))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind lux_to_brightness_curve lbc_checker u_lbc_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .brightness   (brightness),
  .status       (status)
);
